// ----- hw/rtl/nkc_pkg.sv -----
`timescale 1ns / 1ps
// nkc_pkg: shared constants, types and helpers of the normalized kernel convolution block
// no dependencies

package nkc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_KERNEL_DEF = 7;
  localparam int COEF_FRAC_DEF  = 12;

  localparam int ROW_LIMIT = 1024;

  localparam logic [10:0] FW_RESET = 11'd640;
  localparam logic [10:0] FH_RESET = 11'd350;
  localparam logic [2:0]  KS_RESET = 3'd3;

  // register indexes of the configuration port
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;

  // input command codes
  localparam logic CMD_COEF  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // arithmetic widths (hold a 7x7 kernel of 16-bit taps on 8-bit pixels)
  localparam int ACC_W = 32;
  localparam int SUM_W = 24;
  localparam int DIV_W = 40;

  // job header: calc flag, last flag, row, column
  localparam int JOB_HDR_W = 22;

  typedef struct packed {
    logic               we;
    logic [5:0]         idx;
    logic signed [15:0] value;
  } coef_wr_t;

  function automatic logic [2:0] half_of(input logic [2:0] ks, input logic [2:0] hmax);
    logic [2:0] h;
    h = {1'b0, ks[2:1]};
    return (h > hmax) ? hmax : h;
  endfunction

endpackage

// ----- hw/rtl/nkc_if.sv -----
`timescale 1ns / 1ps
// nkc channel interfaces: pixel/coefficient input, result output, configuration write
// no dependencies

interface nkc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [5:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [7:0]         pixel;
  modport source(output valid, cmd, coef_index, coef_value, pixel, input ready);
  modport sink(input valid, cmd, coef_index, coef_value, pixel, output ready);
endinterface

interface nkc_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic [7:0] out_pixel;
  logic       last_of_frame;
  modport source(output valid, out_row, out_col, out_pixel, last_of_frame, input ready);
  modport sink(input valid, out_row, out_col, out_pixel, last_of_frame, output ready);
endinterface

interface nkc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/normalized_kernel_convolution_top.sv -----
`timescale 1ns / 1ps
// Streaming 2-D convolution with a normalized square kernel.
// Channels: in_if carries coefficient writes (cmd 0) and raster pixels (cmd 1);
// out_if carries one result per pixel at (y,x) with y,x >= half the kernel side;
// cfg_if writes frame_width, frame_height and kernel_size and is always ready;
// the user must write them only while idle; the block does not enforce this itself.
// A coefficient write waits until every earlier result has been taken.
// The front takes no new pixel while the last one is still in its registered
// line-memory read, then write-back and window shift. A border result goes straight to
// the output state; a computed result multiplies its side*side taps one by one on
// the single multiplier, drains the tap pipeline, sets up the divide and runs up to
// 9 divide steps (a saturation check, then quotient bits) before the output state.
// A two-entry job queue lets the front keep taking pixels while the back works.
// Reset (synchronous, rst_n low) restores the register defaults, clears counters,
// window and queue; coefficient and line memories are not cleared.
// When the receiver stalls the result is held in the output register and the
// front stops once the queue is full.

module normalized_kernel_convolution_top import nkc_pkg::*; #(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL     = MAX_KERNEL_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nkc_in_if.sink    in_if,
  nkc_out_if.source out_if,
  nkc_cfg_if.sink   cfg_if
);

  localparam int JW = MAX_KERNEL * MAX_KERNEL * 8 + JOB_HDR_W;

  logic [2:0]    ks;
  coef_wr_t      coef_wr;
  logic          back_idle, q_full, q_empty, q_push, q_pop;
  logic [JW-1:0] q_data, q_head;

  nkc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .cfg_if(cfg_if), .ks_o(ks),
    .coef_wr(coef_wr), .back_idle(back_idle), .q_full(q_full), .q_empty(q_empty),
    .q_push(q_push), .q_data(q_data)
  );

  nkc_queue #(.W(JW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  nkc_back #(.MAX_KERNEL(MAX_KERNEL), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .ks(ks), .coef_wr(coef_wr), .q_empty(q_empty),
    .q_head(q_head), .q_pop(q_pop), .back_idle(back_idle), .out_if(out_if)
  );

endmodule

// ----- hw/rtl/nkc_front.sv -----
`timescale 1ns / 1ps
// nkc_front: config registers, raster counters, line memory and window; emits jobs
// depends on nkc_pkg, nkc_if

module nkc_front import nkc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  localparam int JW = MAX_KERNEL * MAX_KERNEL * 8 + JOB_HDR_W
) (
  input  logic          clk,
  input  logic          rst_n,
  nkc_in_if.sink        in_if,
  nkc_cfg_if.sink       cfg_if,
  output logic [2:0]    ks_o,
  output coef_wr_t      coef_wr,
  input  logic          back_idle,
  input  logic          q_full,
  input  logic          q_empty,
  output logic          q_push,
  output logic [JW-1:0] q_data
);

  localparam int K    = MAX_KERNEL;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CW   = (XW + 1 > 11) ? XW + 1 : 11;
  localparam int YMW  = $clog2(K);
  localparam int WB   = K * K * 8;
  localparam int HMAX = (K - 1) / 2;

  typedef enum logic {F_IDLE, F_LOAD} fstate_t;

  fstate_t        st_r;
  logic [10:0]    fw_r, fh_r;
  logic [2:0]     ks_r;
  logic [XW-1:0]  x_r;
  logic [9:0]     y_r;
  logic [YMW-1:0] ym_r;
  logic [7:0]     pix_r;
  logic [WB-1:0]  win_r, win_nxt;
  logic [K*8-1:0] rd_word_r, wr_word;
  logic [K*8-1:0] lmem [MAX_WIDTH];

  logic [CW-1:0]  fw_e, w, xp1, ocol_full;
  logic [10:0]    hgt, yp1;
  logic [2:0]     h;
  logic           col_end, row_end, emit, calc, last, accept;
  logic [9:0]     orow;

  assign cfg_if.ready = 1'b1;
  assign ks_o = ks_r;

  always_comb begin
    fw_e = CW'(fw_r);
    if (fw_e == '0) w = CW'(1);
    else if (fw_e > CW'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    else w = fw_e;
    if (fh_r == 11'd0) hgt = 11'd1;
    else if (fh_r > 11'(ROW_LIMIT)) hgt = 11'(ROW_LIMIT);
    else hgt = fh_r;
    h = half_of(ks_r, 3'(HMAX));
    xp1 = CW'(x_r) + CW'(1);
    yp1 = {1'b0, y_r} + 11'd1;
    col_end = xp1 >= w;
    row_end = yp1 >= hgt;
    last = col_end && row_end;
    emit = (y_r >= 10'(h)) && (CW'(x_r) >= CW'(h));
    orow = y_r - 10'(h);
    ocol_full = CW'(x_r) - CW'(h);
    calc = (orow >= 10'(h)) && (ocol_full >= CW'(h)) &&
           (({1'b0, orow} + 11'(h)) < hgt) && ((ocol_full + CW'(h)) < w);
  end

  // shift the window one column, new column from the line memory plus the new pixel
  always_comb begin
    logic [YMW:0] sel;
    win_nxt = win_r;
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K - 1; c++) begin
        win_nxt[(r*K+c)*8 +: 8] = win_r[(r*K+c+1)*8 +: 8];
      end
    end
    for (int r = 0; r < K - 1; r++) begin
      sel = (YMW+1)'(ym_r) + (YMW+1)'(r + 1);
      if (sel >= (YMW+1)'(K)) sel = sel - (YMW+1)'(K);
      win_nxt[(r*K+K-1)*8 +: 8] = rd_word_r[YMW'(sel)*8 +: 8];
    end
    win_nxt[(K*K-1)*8 +: 8] = pix_r;
    wr_word = rd_word_r;
    wr_word[ym_r*8 +: 8] = pix_r;
  end

  assign in_if.ready = (st_r == F_IDLE) && !q_full &&
                       ((in_if.cmd == CMD_PIXEL) || (q_empty && back_idle));
  assign accept = in_if.valid && in_if.ready;

  assign coef_wr.we    = accept && (in_if.cmd == CMD_COEF);
  assign coef_wr.idx   = in_if.coef_index;
  assign coef_wr.value = in_if.coef_value;

  assign q_push = (st_r == F_LOAD) && emit;
  assign q_data = {calc, last, orow, ocol_full[9:0], win_nxt};

  always_ff @(posedge clk) begin
    rd_word_r <= lmem[x_r];
    if (st_r == F_LOAD) begin
      lmem[x_r] <= wr_word;
    end
    if (accept) begin
      pix_r <= in_if.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      fw_r  <= FW_RESET;
      fh_r  <= FH_RESET;
      ks_r  <= KS_RESET;
      x_r   <= '0;
      y_r   <= '0;
      ym_r  <= '0;
      win_r <= '0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          REG_FRAME_WIDTH:  fw_r <= cfg_if.data;
          REG_FRAME_HEIGHT: fh_r <= cfg_if.data;
          REG_KERNEL_SIZE:  ks_r <= cfg_if.data[2:0];
          default: ;
        endcase
      end
      case (st_r)
        F_IDLE: begin
          if (accept && (in_if.cmd == CMD_PIXEL)) st_r <= F_LOAD;
        end
        F_LOAD: begin
          win_r <= win_nxt;
          if (col_end) begin
            x_r <= '0;
            if (row_end) begin
              y_r  <= '0;
              ym_r <= '0;
            end else begin
              y_r  <= yp1[9:0];
              ym_r <= (ym_r == YMW'(K - 1)) ? '0 : ym_r + YMW'(1);
            end
          end else begin
            x_r <= xp1[XW-1:0];
          end
          st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/nkc_queue.sv -----
`timescale 1ns / 1ps
// nkc_queue: two-entry job queue between front and back
// no dependencies

module nkc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/nkc_back.sv -----
`timescale 1ns / 1ps
// nkc_back: coefficient memory, one-tap-per-cycle multiply-accumulate, restoring divide,
// clamp and output register; depends on nkc_pkg, nkc_if

module nkc_back import nkc_pkg::*; #(
  parameter int MAX_KERNEL     = MAX_KERNEL_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
  localparam int JW = MAX_KERNEL * MAX_KERNEL * 8 + JOB_HDR_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    ks,
  input  coef_wr_t      coef_wr,
  input  logic          q_empty,
  input  logic [JW-1:0] q_head,
  output logic          q_pop,
  output logic          back_idle,
  nkc_out_if.source     out_if
);

  localparam int K    = MAX_KERNEL;
  localparam int TAPS = K * K;
  localparam int TW   = $clog2(TAPS);
  localparam int NW   = $clog2(K + 1);
  localparam int HMAX = (K - 1) / 2;

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_DSET, B_DIV, B_OUT} bstate_t;

  bstate_t                 st_r;
  logic signed [15:0]      cmem [TAPS];
  logic signed [15:0]      coef_q_r, coef2_r;
  logic                    iss_r, v1_r, v2_r;
  logic [NW-1:0]           rr_r, cc_r;
  logic [TW-1:0]           ca_r;
  logic [TW-1:0]           wa_r;
  logic [7:0]              pix1_r;
  logic signed [24:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [DIV_W-1:0]        rem_r, dsh_r;
  logic [3:0]              cnt_r;
  logic [7:0]              qt_r;
  logic [9:0]              orow_r, ocol_r;
  logic [7:0]              opix_r;
  logic                    olast_r;

  logic [2:0]       h;
  logic [NW-1:0]    side, base;
  logic             job_calc, ge, neg, finish;
  logic [7:0]       fin_val;
  logic [DIV_W-1:0] acc_abs, div_abs;

  assign h        = half_of(ks, 3'(HMAX));
  assign side     = NW'({h, 1'b1});
  assign base     = NW'(K) - side;
  assign job_calc = q_head[JW-1];
  assign ge       = rem_r >= dsh_r;

  always_comb begin
    acc_abs = acc_r[ACC_W-1] ? DIV_W'(-acc_r) : DIV_W'(acc_r);
    if (sum_r == '0) div_abs = DIV_W'(1) << COEF_FRAC_BITS;
    else if (sum_r[SUM_W-1]) div_abs = DIV_W'(-sum_r);
    else div_abs = DIV_W'(sum_r);
    neg = (acc_r[ACC_W-1] ^ ((sum_r != '0) && sum_r[SUM_W-1])) && (acc_r != '0);
    finish  = 1'b0;
    fin_val = 8'd0;
    case (st_r)
      B_IDLE: begin
        finish = !q_empty && !job_calc;
      end
      B_DSET: begin
        finish = neg;
      end
      B_DIV: begin
        if (cnt_r == 4'd8) begin
          finish  = ge;
          fin_val = 8'hff;
        end else begin
          finish  = cnt_r == 4'd0;
          fin_val = {qt_r[6:0], ge};
        end
      end
      default: ;
    endcase
  end

  assign q_pop     = finish;
  assign back_idle = st_r == B_IDLE;

  assign out_if.valid         = st_r == B_OUT;
  assign out_if.out_row       = orow_r;
  assign out_if.out_col       = ocol_r;
  assign out_if.out_pixel     = opix_r;
  assign out_if.last_of_frame = olast_r;

  // coefficient memory and tap pipeline (payload, no reset)
  always_ff @(posedge clk) begin
    if (coef_wr.we && (32'(coef_wr.idx) < TAPS)) begin
      cmem[TW'(coef_wr.idx)] <= coef_wr.value;
    end
    coef_q_r <= cmem[ca_r];
    pix1_r   <= q_head[wa_r*8 +: 8];
    prod_r   <= coef_q_r * $signed({1'b0, pix1_r});
    coef2_r  <= coef_q_r;
    if (finish) begin
      orow_r  <= q_head[JW-3 -: 10];
      ocol_r  <= q_head[JW-13 -: 10];
      olast_r <= q_head[JW-2];
      opix_r  <= fin_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      iss_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      v1_r <= iss_r;
      v2_r <= v1_r;
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
        sum_r <= sum_r + SUM_W'(coef2_r);
      end
      case (st_r)
        B_IDLE: begin
          if (finish) begin
            st_r <= B_OUT;
          end else if (!q_empty) begin
            rr_r  <= '0;
            cc_r  <= '0;
            ca_r  <= '0;
            wa_r  <= TW'(int'(base) * K + int'(base));
            acc_r <= '0;
            sum_r <= '0;
            iss_r <= 1'b1;
            st_r  <= B_MAC;
          end
        end
        B_MAC: begin
          if (iss_r) begin
            ca_r <= ca_r + TW'(1);
            if (cc_r == side - NW'(1)) begin
              cc_r <= '0;
              rr_r <= rr_r + NW'(1);
              wa_r <= wa_r + TW'(K + 1) - TW'(side);
              if (rr_r == side - NW'(1)) iss_r <= 1'b0;
            end else begin
              cc_r <= cc_r + NW'(1);
              wa_r <= wa_r + TW'(1);
            end
          end else if (!v1_r && !v2_r) begin
            st_r <= B_DSET;
          end
        end
        B_DSET: begin
          rem_r <= acc_abs;
          dsh_r <= div_abs << 8;
          cnt_r <= 4'd8;
          qt_r  <= 8'd0;
          st_r  <= finish ? B_OUT : B_DIV;
        end
        B_DIV: begin
          // first step checks for saturation, then one quotient bit per cycle
          if (cnt_r != 4'd8) begin
            qt_r <= {qt_r[6:0], ge};
            if (ge) rem_r <= rem_r - dsh_r;
          end
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 4'd1;
          if (finish) st_r <= B_OUT;
        end
        B_OUT: begin
          if (out_if.ready) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/nkc_checker.sv -----
`timescale 1ns / 1ps
// nkc_checker: port-level assertions for the convolution top level, with its bind
// depends on nkc_pkg and normalized_kernel_convolution_top

module nkc_checker import nkc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_row,
  input logic [9:0] out_col,
  input logic [7:0] out_pixel
);

  logic [11:0] pend_r;
  logic        sat_r;
  logic        pix_xfer, out_xfer;

  assign pix_xfer = in_valid && in_ready && (in_cmd == CMD_PIXEL);
  assign out_xfer = out_valid && out_ready;

  // pixels transferred minus results transferred, tracking stops on saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      sat_r  <= 1'b0;
    end else if (!sat_r) begin
      if (pix_xfer && !out_xfer) begin
        if (pend_r == '1) sat_r <= 1'b1;
        else pend_r <= pend_r + 12'd1;
      end else if (!pix_xfer && out_xfer) begin
        pend_r <= pend_r - 12'd1;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col) &&
    $stable(out_pixel))
    else $error("stalled result changed");

  a_coef_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_COEF) |-> !out_valid)
    else $error("coefficient write taken while a result is pending");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sat_r || (pend_r != '0))
    else $error("result without a pixel behind it");

endmodule

bind normalized_kernel_convolution_top nkc_checker u_nkc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_cmd(in_if.cmd),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_row(out_if.out_row), .out_col(out_if.out_col), .out_pixel(out_if.out_pixel)
);

// ----- test/normalized_kernel_convolution_top_tb.sv -----
`timescale 1ns / 1ps
// normalized_kernel_convolution_top_tb: self-checking bench for the streaming normalized
// kernel convolution; drives config, coefficient and pixel transfers, checks every result.
// Depends on nkc_pkg, nkc_if and normalized_kernel_convolution_top.

module normalized_kernel_convolution_top_tb;
  import nkc_pkg::*;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] pix;
    logic       last;
  } conv_result_t;

  typedef struct {
    logic               cmd;
    logic [5:0]         idx;
    logic signed [15:0] val;
    logic [7:0]         pix;
    bit                 typed;
    conv_result_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nkc_in_if  in_ch();
  nkc_out_if out_ch();
  nkc_cfg_if cfg_ch();

  normalized_kernel_convolution_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch), .cfg_if(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the block state
  logic signed [15:0] taps [49];
  logic [7:0]         lines [7][1024];
  logic [7:0]         win [7][7];
  int unsigned        row_pos, col_pos;
  logic [10:0]        cur_width, cur_height;
  logic [2:0]         cur_ksize;

  conv_result_t pending_pixels [$];
  int  errors = 0;
  int  items_sent = 0;
  bit  calm = 1'b0;
  longint cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("FAIL normalized_kernel_convolution_top");
      $finish;
    end
  end

  task automatic predict_pixel(input logic [7:0] pix, output bit has, output conv_result_t res);
    int unsigned h, side, w, hg, x, y, orow, ocol, base;
    longint acc, s, q;
    has = 1'b0;
    res = '0;
    h = cur_ksize >> 1;
    if (h > 3) h = 3;
    side = 2 * h + 1;
    w = (cur_width < 1) ? 1 : ((cur_width > 1024) ? 1024 : cur_width);
    hg = (cur_height < 1) ? 1 : ((cur_height > 1024) ? 1024 : cur_height);
    x = (col_pos < 1024) ? col_pos : 1023;
    y = row_pos;
    for (int r = 0; r < 7; r++)
      for (int c = 0; c < 6; c++) win[r][c] = win[r][c + 1];
    for (int r = 0; r < 6; r++) win[r][6] = lines[(y + 7 - (6 - r)) % 7][x];
    win[6][6] = pix;
    lines[y % 7][x] = pix;
    res.last = (x + 1 >= w) && (y + 1 >= hg);
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= hg) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    if (y < h || x < h) return;
    has = 1'b1;
    orow = y - h;
    ocol = x - h;
    res.row = orow[9:0];
    res.col = ocol[9:0];
    if (orow >= h && ocol >= h && orow + h < hg && ocol + h < w) begin
      base = 7 - side;
      acc = 0;
      s = 0;
      for (int r = 0; r < side; r++)
        for (int c = 0; c < side; c++) begin
          acc += longint'(taps[r * side + c]) * longint'(win[base + r][base + c]);
          s += taps[r * side + c];
        end
      // a zero tap sum divides by one in Q.12
      q = (s != 0) ? acc / s : acc / 4096;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      res.pix = q[7:0];
    end
  endtask

  task automatic send(input logic cmd, input logic [5:0] idx, input logic signed [15:0] val,
                      input logic [7:0] pix, input bit typed, input conv_result_t want);
    bit has;
    conv_result_t res;
    if (!calm && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    in_ch.pixel <= pix;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (cmd == CMD_COEF) begin
      if (idx < 49) taps[idx] = val;
    end else begin
      predict_pixel(pix, has, res);
      if (typed) pending_pixels.push_back(want);
      else if (has) pending_pixels.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_FRAME_WIDTH:  cur_width = data;
      REG_FRAME_HEIGHT: cur_height = data;
      default:          cur_ksize = data[2:0];
    endcase
  endtask

  task automatic configure(input logic [10:0] w, input logic [10:0] hg, input logic [2:0] ks);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, hg);
    write_reg(REG_KERNEL_SIZE, {8'd0, ks});
    cfg_ch.valid <= 1'b0;
  endtask

  // settle until all results are in, then give the back end time to finish
  task automatic drain(input int quiet);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    conv_result_t exp_r;
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 25);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result row %0d col %0d pixel %0d", $time,
                 out_ch.out_row, out_ch.out_col, out_ch.out_pixel);
        errors++;
      end else begin
        exp_r = pending_pixels.pop_front();
        check_field("row", exp_r.row, out_ch.out_row);
        check_field("col", exp_r.col, out_ch.out_col);
        check_field("pixel", exp_r.pix, out_ch.out_pixel);
        check_field("last", exp_r.last, out_ch.last_of_frame);
      end
    end
  end

  stim_row_t directed [16];
  logic [7:0] frame_pix [12] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd10, 8'd200, 8'd0,
                                 8'd1, 8'd2, 8'd3, 8'd255};

  initial begin
    int unsigned w, hg, ks, side, nframes, kind, phase;
    logic signed [15:0] cv;
    int tap_total;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_PIXEL;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FRAME_WIDTH;
    cfg_ch.data = '0;
    cur_width = FW_RESET;
    cur_height = FH_RESET;
    cur_ksize = KS_RESET;
    row_pos = 0;
    col_pos = 0;
    foreach (taps[i]) taps[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    foreach (lines[r, c]) lines[r][c] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 4x3 frame, 3x3 kernel, all taps cleared first
    configure(11'd4, 11'd3, 3'd3);
    for (int i = 0; i < 49; i++) send(CMD_COEF, 6'(i), 16'sd0, 8'd0, 1'b0, '0);
    drain(0);

    directed[0] = '{CMD_COEF, 6'd4, 16'sd4096, 8'd0, 1'b0, '0};
    directed[1] = '{CMD_COEF, 6'd63, 16'sd32767, 8'd0, 1'b0, '0};  // index past the store
    directed[2] = '{CMD_COEF, 6'd0, -16'sd32768, 8'd0, 1'b0, '0};
    directed[3] = '{CMD_COEF, 6'd0, 16'sd0, 8'd0, 1'b0, '0};
    for (int i = 0; i < 12; i++)
      directed[4 + i] = '{CMD_PIXEL, 6'd0, 16'sd0, frame_pix[i], 1'b0, '0};
    // border results are zero; center tap 1.0 passes the middle row through
    directed[9].typed = 1'b1;  directed[9].want = '{10'd0, 10'd0, 8'd0, 1'b0};
    directed[10].typed = 1'b1; directed[10].want = '{10'd0, 10'd1, 8'd0, 1'b0};
    directed[11].typed = 1'b1; directed[11].want = '{10'd0, 10'd2, 8'd0, 1'b0};
    directed[13].typed = 1'b1; directed[13].want = '{10'd1, 10'd0, 8'd0, 1'b0};
    directed[14].typed = 1'b1; directed[14].want = '{10'd1, 10'd1, 8'd10, 1'b0};
    directed[15].typed = 1'b1; directed[15].want = '{10'd1, 10'd2, 8'd200, 1'b1};
    foreach (directed[i])
      send(directed[i].cmd, directed[i].idx, directed[i].val, directed[i].pix,
           directed[i].typed, directed[i].want);

    phase = 0;
    while (items_sent < 1500) begin
      drain(80);
      phase++;
      calm = (phase >= 2 && phase <= 4);
      ks = $urandom_range(7);
      // the first phase is a frame at the size limits, the rest are small frames
      kind = (phase == 1) ? $urandom_range(11) : 12 + $urandom_range(87);
      if (kind < 6) begin
        w = ($urandom_range(1)) ? 1024 : 2047;
        hg = 1;
        ks = $urandom_range(3);
      end else if (kind < 12) begin
        w = $urandom_range(1);
        hg = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1)) ? 1024 : 2047);
      end else begin
        w = $urandom_range(24, 1);
        hg = $urandom_range(10, 1);
      end
      configure(w[10:0], hg[10:0], ks[2:0]);

      // fresh kernel: normalized, full range or zero sum
      side = 2 * ((ks >> 1) > 3 ? 3 : (ks >> 1)) + 1;
      kind = $urandom_range(2);
      tap_total = 0;
      for (int i = 0; i < side * side; i++) begin
        if (kind == 0) cv = 16'($urandom_range(1200));
        else if (kind == 1) cv = 16'($urandom);
        else if (i == side * side - 1) cv = 16'(-tap_total);
        else cv = $signed(16'($urandom_range(1000))) - 16'sd500;
        tap_total += cv;
        send(CMD_COEF, 6'(i), cv, 8'd0, 1'b0, '0);
      end
      if ($urandom_range(3) == 0)
        send(CMD_COEF, 6'($urandom_range(63, 49)), 16'($urandom), 8'd0, 1'b0, '0);

      nframes = (w > 24 || hg > 10 || hg == 0) ? 1 : $urandom_range(3, 1);
      if (w == 0) w = 1;
      if (w > 1024) w = 1024;
      if (hg == 0) hg = 1;
      if (hg > 1024) hg = 1024;
      for (int f = 0; f < nframes; f++)
        for (int p = 0; p < w * hg; p++) begin
          if (phase == 2 && f == 0 && p == (w * hg) / 2) drain(0);
          if ($urandom_range(99) < 2)
            send(CMD_COEF, 6'($urandom_range(side * side - 1)), 16'($urandom_range(1500)),
                 8'd0, 1'b0, '0);
          kind = $urandom_range(9);
          send(CMD_PIXEL, 6'($urandom), 16'($urandom),
               (kind == 0) ? 8'd0 : ((kind == 1) ? 8'd255 : 8'($urandom)), 1'b0, '0);
        end
    end

    calm = 1'b0;
    drain(100);
    if (errors == 0) begin
      $display("PASS normalized_kernel_convolution_top");
    end else begin
      $display("FAIL normalized_kernel_convolution_top");
    end
    $finish;
  end

endmodule

// ----- normalized_kernel_convolution_top.f -----
hw/rtl/nkc_pkg.sv
hw/rtl/nkc_if.sv
hw/rtl/nkc_front.sv
hw/rtl/nkc_queue.sv
hw/rtl/nkc_back.sv
hw/rtl/normalized_kernel_convolution_top.sv
hw/rtl/nkc_checker.sv
test/normalized_kernel_convolution_top_tb.sv
